### hdl/sbr_pkg.sv
// Shared types and constants for the stream byte reassembler.
package sbr_pkg;

  localparam int BYTE_W     = 8;
  localparam int SLOT_IDX_W = 6;

  typedef struct packed {
    logic                  wr_en;
    logic [SLOT_IDX_W-1:0] wr_slot;
    logic [BYTE_W-1:0]     wr_data;
    logic                  rd_en;
    logic [SLOT_IDX_W-1:0] rd_slot;
  } ring_req_t;

endpackage

### hdl/stream_byte_reassembler_core.sv
// Top level of the stream byte reassembler: window check, release sequencer and result port.
//
// A request is taken when start is high and busy is low. In that cycle the byte is checked
// against the window and written into the slot ring. Then the block releases held bytes in
// stream order, one per cycle through the ring memory's read port; a request that releases
// nothing gives one status result. Each result sits on the out_ ports for exactly one cycle,
// marked by out_strobe, and must be taken then: the receiver cannot stall the block. The last
// result of a request carries out_last_in_run.
module stream_byte_reassembler_core #(
  parameter int WINDOW = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_has_byte,
  input  logic [7:0]  in_data_byte,
  input  logic [63:0] in_stream_index,
  input  logic        in_is_final,
  input  logic [6:0]  in_room,
  output logic        out_strobe,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        out_last_in_run,
  output logic        out_stream_closed,
  output logic [6:0]  out_pending_count
);

  localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  state_t      state_r;
  logic [63:0] ne_r;
  logic [SW-1:0] ns_r;
  logic [6:0]  held_cnt_r;
  logic        end_known_r;
  logic [63:0] end_idx_r;
  logic        closed_r;
  logic        out_strobe_r;
  logic        out_valid_r;
  logic        out_last_r;
  logic        out_closed_r;
  logic [6:0]  out_pending_r;

  logic [WINDOW-1:0] held;
  logic [7:0]        rd_data;
  sbr_pkg::ring_req_t ring_req;

  logic        accept;
  logic [6:0]  room_eff;
  logic [63:0] offset;
  logic        in_window;
  logic [7:0]  slot_sum;
  logic [7:0]  slot_adj;
  logic [SW-1:0] st_slot;
  logic        do_store;
  logic        end_known_nxt;
  logic [63:0] end_idx_nxt;
  logic        closed_nxt;

  logic [SW-1:0] ns_inc;
  logic [63:0] ne_inc;
  logic [6:0]  held_dec;
  logic        closed_drain;
  logic        head_held;

  assign accept   = start && (state_r == ST_IDLE);
  assign room_eff = (in_room > 7'(WINDOW)) ? 7'(WINDOW) : in_room;
  assign offset   = in_stream_index - ne_r;
  assign in_window = (in_stream_index >= ne_r) && (offset < {57'd0, room_eff});
  assign slot_sum = 8'(ns_r) + {1'b0, offset[6:0]};
  assign slot_adj = (slot_sum >= 8'(WINDOW)) ? (slot_sum - 8'(WINDOW)) : slot_sum;
  assign st_slot  = slot_adj[SW-1:0];
  assign do_store = accept && in_has_byte && !closed_r && in_window && !held[st_slot];

  always_comb begin
    end_known_nxt = end_known_r;
    end_idx_nxt   = end_idx_r;
    if (in_is_final && !end_known_r) begin
      end_known_nxt = 1'b1;
      end_idx_nxt   = in_has_byte ? (in_stream_index + 64'd1) : in_stream_index;
    end
    closed_nxt = closed_r || (end_known_nxt && (ne_r >= end_idx_nxt));
  end

  assign ns_inc       = (ns_r == SW'(WINDOW - 1)) ? '0 : (ns_r + SW'(1));
  assign ne_inc       = ne_r + 64'd1;
  assign held_dec     = (held_cnt_r != 7'd0) ? (held_cnt_r - 7'd1) : held_cnt_r;
  assign closed_drain = closed_r || (end_known_r && (ne_inc >= end_idx_r));
  assign head_held    = held[ns_r];

  always_comb begin
    ring_req         = '0;
    ring_req.wr_en   = do_store;
    ring_req.wr_slot = sbr_pkg::SLOT_IDX_W'(st_slot);
    ring_req.wr_data = in_data_byte;
    ring_req.rd_en   = (state_r == ST_DRAIN) && head_held;
    ring_req.rd_slot = sbr_pkg::SLOT_IDX_W'(ns_r);
  end

  sbr_ring #(
    .WINDOW(WINDOW)
  ) u_ring (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (ring_req),
    .held   (held),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      ne_r          <= '0;
      ns_r          <= '0;
      held_cnt_r    <= '0;
      end_known_r   <= 1'b0;
      end_idx_r     <= '0;
      closed_r      <= 1'b0;
      out_strobe_r  <= 1'b0;
      out_valid_r   <= 1'b0;
      out_last_r    <= 1'b0;
      out_closed_r  <= 1'b0;
      out_pending_r <= '0;
    end else begin
      out_strobe_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            end_known_r <= end_known_nxt;
            end_idx_r   <= end_idx_nxt;
            closed_r    <= closed_nxt;
            if (do_store) begin
              held_cnt_r <= held_cnt_r + 7'd1;
            end
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          out_strobe_r <= 1'b1;
          if (head_held) begin
            ne_r          <= ne_inc;
            ns_r          <= ns_inc;
            held_cnt_r    <= held_dec;
            closed_r      <= closed_drain;
            out_valid_r   <= 1'b1;
            out_last_r    <= !held[ns_inc];
            out_closed_r  <= closed_drain;
            out_pending_r <= held_dec;
            if (!held[ns_inc]) begin
              state_r <= ST_IDLE;
            end
          end else begin
            out_valid_r   <= 1'b0;
            out_last_r    <= 1'b1;
            out_closed_r  <= closed_r;
            out_pending_r <= held_cnt_r;
            state_r       <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_strobe        = out_strobe_r;
  assign out_valid         = out_valid_r;
  assign out_byte          = out_valid_r ? rd_data : 8'd0;
  assign out_last_in_run   = out_last_r;
  assign out_stream_closed = out_closed_r;
  assign out_pending_count = out_pending_r;

endmodule

### hdl/sbr_ring.sv
// Slot ring: byte memory with a registered read port and per-slot held marks.
module sbr_ring #(
  parameter int WINDOW = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sbr_pkg::ring_req_t          req,
  output logic [WINDOW-1:0]           held,
  output logic [sbr_pkg::BYTE_W-1:0]  rd_data
);

  localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic [sbr_pkg::BYTE_W-1:0] slot_mem [WINDOW];
  logic [sbr_pkg::BYTE_W-1:0] rd_data_r;
  logic [WINDOW-1:0]          held_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      slot_mem[req.wr_slot[SW-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= slot_mem[req.rd_slot[SW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else begin
      if (req.wr_en) begin
        held_r[req.wr_slot[SW-1:0]] <= 1'b1;
      end
      if (req.rd_en) begin
        held_r[req.rd_slot[SW-1:0]] <= 1'b0;
      end
    end
  end

  assign held    = held_r;
  assign rd_data = rd_data_r;

endmodule

### dv/tb_stream_byte_reassembler_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for the stream byte reassembler core, with its own reassembly model.
module tb_stream_byte_reassembler_core;

  localparam int WIN        = 64;
  localparam int IDLE_LIMIT = 2000;
  localparam int DIR_ROWS   = 15;
  localparam int RAND_ITEMS = 500;

  typedef struct packed {
    logic        has_byte;
    logic [7:0]  data;
    logic [63:0] index;
    logic        is_final;
    logic [6:0]  room;
  } request_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
    logic       closed;
    logic [6:0] pending;
  } release_t;

  typedef struct packed {
    request_t req;
    logic     fixed;
    release_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  request_t    req = '0;
  logic        row_fixed = 1'b0;
  release_t    row_want = '0;
  logic        busy;
  logic        out_strobe;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_last_in_run;
  logic        out_stream_closed;
  logic [6:0]  out_pending_count;

  logic [7:0]  ring_data [WIN];
  bit          ring_held [WIN];
  logic [63:0] next_idx = '0;
  int unsigned held_n = 0;
  bit          end_seen = 1'b0;
  logic [63:0] end_at = '0;
  bit          closed = 1'b0;

  release_t    step_releases[$];
  release_t    exp_releases[$];
  int unsigned accepted_n = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned errors = 0;
  bit          progress;

  // Columns: request (has, data, index, final, room), fixed flag, release (v, byte, last, cl, pend).
  dir_row_t dir_table [DIR_ROWS] = '{
    {1'b0, 8'h00, 64'd0, 1'b0, 7'd64, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0, 7'd0},
    {1'b1, 8'h3C, 64'd0, 1'b0, 7'd0, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0, 7'd0},
    {1'b1, 8'hFF, 64'd1, 1'b0, 7'd64, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0, 7'd1},
    {1'b1, 8'h00, 64'd1, 1'b0, 7'd64, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0, 7'd1},
    {1'b1, 8'h00, 64'd0, 1'b0, 7'd1, 1'b0, 18'd0},
    {1'b1, 8'h55, 64'd0, 1'b0, 7'd64, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0, 7'd0},
    {1'b1, 8'hAA, 64'd65, 1'b0, 7'd127, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0, 7'd1},
    {1'b1, 8'h11, 64'd66, 1'b0, 7'd127, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0, 7'd1},
    {1'b1, 8'h22, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 7'd64, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0, 7'd1},
    {1'b1, 8'h80, 64'd2, 1'b0, 7'd2, 1'b0, 18'd0},
    {1'b0, 8'h7F, 64'd3, 1'b0, 7'd64, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0, 7'd1},
    {1'b1, 8'h01, 64'd4, 1'b0, 7'd100, 1'b0, 18'd0},
    {1'b1, 8'hC3, 64'd3, 1'b0, 7'd65, 1'b0, 18'd0},
    {1'b1, 8'h22, 64'h8000_0000_0000_0000, 1'b0, 7'd64, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0, 7'd1},
    {1'b0, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 7'd127, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0, 7'd1}
  };

  stream_byte_reassembler_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_has_byte       (req.has_byte),
    .in_data_byte      (req.data),
    .in_stream_index   (req.index),
    .in_is_final       (req.is_final),
    .in_room           (req.room),
    .out_strobe        (out_strobe),
    .out_valid         (out_valid),
    .out_byte          (out_byte),
    .out_last_in_run   (out_last_in_run),
    .out_stream_closed (out_stream_closed),
    .out_pending_count (out_pending_count)
  );

  always #1 clk = ~clk;

  task automatic reassemble(input request_t rq);
    logic [6:0] lim;
    logic [5:0] s;
    release_t   r;
    step_releases.delete();
    if (rq.is_final && !end_seen) begin
      end_seen = 1'b1;
      end_at = rq.has_byte ? rq.index + 64'd1 : rq.index;
    end
    lim = (rq.room > WIN) ? 7'(WIN) : rq.room;
    if (rq.has_byte && !closed && rq.index >= next_idx && (rq.index - next_idx) < lim) begin
      s = rq.index[5:0];
      if (!ring_held[s]) begin
        ring_data[s] = rq.data;
        ring_held[s] = 1'b1;
        held_n++;
      end
    end
    if (end_seen && next_idx >= end_at) closed = 1'b1;
    while (step_releases.size() < WIN && ring_held[next_idx[5:0]]) begin
      s = next_idx[5:0];
      ring_held[s] = 1'b0;
      if (held_n > 0) held_n--;
      next_idx++;
      if (end_seen && next_idx >= end_at) closed = 1'b1;
      r = {1'b1, ring_data[s], 1'b0, closed, held_n[6:0]};
      step_releases.push_back(r);
    end
    if (step_releases.size() == 0) step_releases.push_back({1'b0, 8'h00, 1'b0, closed, held_n[6:0]});
    r = step_releases.pop_back();
    r.last = 1'b1;
    step_releases.push_back(r);
  endtask

  task automatic cmp(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s expected %0d actual %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic row_check(input release_t e);
    cmp("out_valid", 8'(e.valid), 8'(out_valid));
    cmp("out_byte", e.data, out_byte);
    cmp("out_last_in_run", 8'(e.last), 8'(out_last_in_run));
    cmp("out_stream_closed", 8'(e.closed), 8'(out_stream_closed));
    cmp("out_pending_count", 8'(e.pending), 8'(out_pending_count));
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      progress = 1'b0;
      if (out_strobe) begin
        progress = 1'b1;
        if (exp_releases.size() == 0) begin
          $error("out_strobe expected 0 actual 1 (byte %0d)", out_byte);
          errors++;
        end else begin
          row_check(exp_releases.pop_front());
        end
      end
      if (start && !busy) begin
        progress = 1'b1;
        reassemble(req);
        if (row_fixed) exp_releases.push_back(row_want);
        else foreach (step_releases[i]) exp_releases.push_back(step_releases[i]);
        accepted_n <= accepted_n + 1;
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send(input request_t rq, input logic fixed, input release_t want);
    int unsigned seen;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    req <= rq;
    row_fixed <= fixed;
    row_want <= want;
    start <= 1'b1;
    seen = accepted_n;
    do @(negedge clk); while (accepted_n == seen);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (exp_releases.size() != 0);
  endtask

  task automatic random_stream(input int target);
    int          n;
    int          len;
    int          j;
    int          t;
    int          offs [WIN];
    bit          big;
    bit          paused;
    logic [63:0] base;
    request_t    rq;
    n = 0;
    paused = 1'b0;
    while (n < target) begin
      if (!paused && n >= target / 2) begin
        drain();
        paused = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        rq.has_byte = ($urandom_range(0, 3) != 0);
        rq.data = 8'($urandom);
        case ($urandom_range(0, 2))
          0: rq.index = {$urandom, $urandom};
          1: rq.index = (next_idx >= 64'd8) ? next_idx - 64'($urandom_range(1, 8)) : 64'd0;
          default: rq.index = next_idx + 64'd64 + 64'($urandom_range(0, 63));
        endcase
        rq.is_final = 1'b0;
        rq.room = 7'($urandom_range(0, 127));
        send(rq, 1'b0, '0);
        n++;
      end else begin
        big = ($urandom_range(0, 14) == 0);
        len = big ? WIN : $urandom_range(1, 8);
        base = (big || $urandom_range(0, 1)) ? next_idx : next_idx + 64'($urandom_range(1, 3));
        for (int i = 0; i < len; i++) offs[i] = i;
        for (int i = len - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          t = offs[i];
          offs[i] = offs[j];
          offs[j] = t;
        end
        // The head byte goes last, so the whole window is released by one request.
        if (big) begin
          for (int i = 0; i < len; i++) begin
            if (offs[i] == 0) begin
              offs[i] = offs[len - 1];
              offs[len - 1] = 0;
            end
          end
        end
        for (int i = 0; i < len; i++) begin
          rq.has_byte = 1'b1;
          rq.data = 8'($urandom);
          rq.index = base + 64'(offs[i]);
          rq.is_final = 1'b0;
          rq.room = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127)) : 7'd64;
          send(rq, 1'b0, '0);
          n++;
          if ($urandom_range(0, 11) == 0) begin
            send(rq, 1'b0, '0);
            n++;
          end
        end
      end
    end
  endtask

  task automatic close_stream();
    logic [63:0] b;
    logic [7:0]  d;
    int          offs [4];
    offs = '{4, 3, 1, 0};
    b = next_idx;
    d = 8'($urandom);
    // A request whose end index wraps round to zero closes the stream at once.
    if ($urandom_range(0, 3) == 0) send({1'b1, d, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 7'd64}, 1'b0, '0);
    send({1'b0, d, b + 64'd2, 1'b1, 7'd64}, 1'b0, '0);
    send({1'b1, ~d, b + 64'd40, 1'b1, 7'd64}, 1'b0, '0);
    foreach (offs[i]) begin
      d = 8'($urandom);
      send({1'b1, d, b + 64'(offs[i]), 1'b0, 7'd64}, 1'b0, '0);
    end
    d = 8'($urandom);
    send({1'b1, d, next_idx, 1'b0, 7'd64}, 1'b0, '0);
    send({1'b0, ~d, next_idx, 1'b0, 7'd64}, 1'b0, '0);
    send({1'b1, d, next_idx + 64'd1, 1'b1, 7'd127}, 1'b0, '0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (dir_table[i]) send(dir_table[i].req, dir_table[i].fixed, dir_table[i].want);
    random_stream(RAND_ITEMS);
    close_stream();
    drain();
    repeat (80) @(negedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
